@@ hw/rtl/rmk_pkg.sv @@
// shared types, constants and helper functions for the minimum k-mer finder
package rmk_pkg;

  localparam int unsigned KMER_W       = 62;
  localparam int unsigned POS_W        = 16;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned KLEN_W       = 5;
  localparam int unsigned CODE_W       = 3;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned MAX_READ_LEN = 65536;

  localparam int unsigned POS_CAP_I = (MAX_READ_LEN - 1 > 65535) ? 65535 : (MAX_READ_LEN - 1);
  localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_I);

  localparam logic [KLEN_W-1:0] KLEN_RESET = 5'd15;

  // register index as decoded from paddr
  localparam logic REG_KMER_LEN = 1'b0;

  // base codes
  localparam logic [CODE_W-1:0] CODE_A     = 3'd0;
  localparam logic [CODE_W-1:0] CODE_C     = 3'd1;
  localparam logic [CODE_W-1:0] CODE_G     = 3'd2;
  localparam logic [CODE_W-1:0] CODE_T     = 3'd3;
  localparam logic [CODE_W-1:0] CODE_OTHER = 3'd4;

  typedef logic [KMER_W-1:0] kmer_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [KLEN_W-1:0] klen_t;

  typedef struct packed {
    klen_t k;
    kmer_t mask;
    logic  clear;
  } cfg_t;

  typedef struct packed {
    kmer_t min_kmer;
    pos_t  min_position;
    kmer_t first_kmer;
    kmer_t last_kmer;
    logic  short_read;
  } res_t;

  function automatic klen_t eff_k(input klen_t k);
    eff_k = (k == '0) ? klen_t'(1) : k;
  endfunction

  function automatic kmer_t kmask(input klen_t k);
    logic [5:0] sh;
    sh = 6'(KMER_W) - {k, 1'b0};
    kmask = {KMER_W{1'b1}} >> sh;
  endfunction

  function automatic logic [CODE_W-1:0] base_code(input logic [CHAR_W-1:0] c);
    case (c)
      8'h41, 8'h61: base_code = CODE_A;
      8'h43, 8'h63: base_code = CODE_C;
      8'h47, 8'h67: base_code = CODE_G;
      8'h54, 8'h74: base_code = CODE_T;
      default:      base_code = CODE_OTHER;
    endcase
  endfunction

endpackage

@@ hw/rtl/rmk_if.sv @@
// valid/ready channel interfaces for read characters and per-read results
interface rmk_in_if;
  import rmk_pkg::*;
  logic                valid;
  logic                ready;
  logic [CHAR_W-1:0]   base_char;
  logic                read_end;

  modport source (output valid, base_char, read_end, input ready);
  modport sink   (input valid, base_char, read_end, output ready);
endinterface

interface rmk_out_if;
  import rmk_pkg::*;
  logic  valid;
  logic  ready;
  kmer_t min_kmer;
  pos_t  min_position;
  kmer_t first_kmer;
  kmer_t last_kmer;
  logic  short_read;

  modport source (output valid, min_kmer, min_position, first_kmer, last_kmer, short_read,
                  input ready);
  modport sink   (input valid, min_kmer, min_position, first_kmer, last_kmer, short_read,
                  output ready);
endinterface

@@ hw/rtl/rmk_cfg.sv @@
// apb register block holding the k-mer length and its derived mask
module rmk_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rmk_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rmk_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rmk_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output rmk_pkg::cfg_t                   cfg
);
  import rmk_pkg::*;

  klen_t kmer_len_r;
  klen_t k_r;
  kmer_t mask_r;
  logic  clear_r;
  logic  wr_en;
  klen_t k_nxt;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_KMER_LEN);
  assign k_nxt  = eff_k(pwdata[KLEN_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_len_r <= KLEN_RESET;
      k_r        <= eff_k(KLEN_RESET);
      mask_r     <= kmask(eff_k(KLEN_RESET));
      clear_r    <= 1'b0;
    end else begin
      clear_r <= wr_en;
      if (wr_en) begin
        kmer_len_r <= pwdata[KLEN_W-1:0];
        k_r        <= k_nxt;
        mask_r     <= kmask(k_nxt);
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_KMER_LEN) begin
      prdata = {{(APB_DATA_W-KLEN_W){1'b0}}, kmer_len_r};
    end
  end

  assign cfg.k     = k_r;
  assign cfg.mask  = mask_r;
  assign cfg.clear = clear_r;

endmodule

@@ hw/rtl/rmk_core.sv @@
// input register and per-base rolling k-mer and minimum update
module rmk_core (
  input  logic           clk,
  input  logic           rst_n,
  input  rmk_pkg::cfg_t  cfg,
  rmk_in_if.sink         in_ch,
  input  logic           res_room,
  output logic           res_valid,
  output rmk_pkg::res_t  res
);
  import rmk_pkg::*;

  logic              s1_valid_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic              s1_end_r;
  logic              s1_go;
  logic              in_acc;

  kmer_t rolling_r, rolling_nxt;
  kmer_t best_r, best_nxt;
  pos_t  bestpos_r, bestpos_nxt;
  pos_t  count_r, count_nxt;
  kmer_t prefix_r, prefix_nxt;

  logic [POS_W:0] seen;
  logic [POS_W:0] k_ext;
  logic           short_r;

  assign s1_go       = s1_valid_r && (!s1_end_r || res_room);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_ch.base_char;
      s1_end_r  <= in_ch.read_end;
    end
  end

  // rolling k-mer, minimum tracking
  assign seen    = {1'b0, count_r} + 17'd1;
  assign k_ext   = {{(POS_W+1-KLEN_W){1'b0}}, cfg.k};
  assign short_r = seen < k_ext;

  always_comb begin
    rolling_nxt = ({rolling_r[KMER_W-3:0], 2'b00} | KMER_W'(base_code(s1_char_r))) & cfg.mask;
    count_nxt   = (count_r < POS_CAP) ? count_r + 16'd1 : count_r;
    prefix_nxt  = (seen == k_ext) ? rolling_nxt : prefix_r;
    best_nxt    = best_r;
    bestpos_nxt = bestpos_r;
    if (!short_r && (rolling_nxt < best_r)) begin
      best_nxt    = rolling_nxt;
      bestpos_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rolling_r <= '0;
      best_r    <= kmask(eff_k(KLEN_RESET));
      bestpos_r <= '0;
      count_r   <= '0;
      prefix_r  <= '0;
    end else if (cfg.clear || (s1_go && s1_end_r)) begin
      rolling_r <= '0;
      best_r    <= cfg.mask;
      bestpos_r <= '0;
      count_r   <= '0;
      prefix_r  <= '0;
    end else if (s1_go) begin
      rolling_r <= rolling_nxt;
      best_r    <= best_nxt;
      bestpos_r <= bestpos_nxt;
      count_r   <= count_nxt;
      prefix_r  <= prefix_nxt;
    end
  end

  assign res_valid        = s1_go && s1_end_r;
  assign res.min_kmer     = best_nxt;
  assign res.min_position = short_r ? '0 : bestpos_nxt;
  assign res.first_kmer   = short_r ? rolling_nxt : prefix_nxt;
  assign res.last_kmer    = rolling_nxt;
  assign res.short_read   = short_r;

  a_end_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_end_r && !res_room |=> s1_valid_r)
    else $error("end word dropped while result side was full");

  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.clear |=> count_r == '0)
    else $error("base count not cleared after length write");

  a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && !s1_end_r && !cfg.clear |=> count_r != '0)
    else $error("base count zero after a mid-read base");

endmodule

@@ hw/rtl/rmk_out.sv @@
// result register on the output channel
module rmk_out (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid,
  input  rmk_pkg::res_t  res,
  output logic           res_room,
  rmk_out_if.source      out_ch
);
  import rmk_pkg::*;

  logic out_valid_r;
  res_t res_r;

  assign res_room = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.min_kmer     = res_r.min_kmer;
  assign out_ch.min_position = res_r.min_position;
  assign out_ch.first_kmer   = res_r.first_kmer;
  assign out_ch.last_kmer    = res_r.last_kmer;
  assign out_ch.short_read   = res_r.short_read;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res_room)
    else $error("result register overwritten before it was taken");

endmodule

@@ hw/rtl/read_min_kmer_finder.sv @@
// Minimum k-mer finder: takes one read character per word, every clock cycle while no end
// word waits on a full result register, and keeps a rolling 2k-bit forward k-mer (A/C/G/T in
// either case give 0..3, other characters OR in 4). The last character of a read (read_end)
// produces one result word with the smallest k-mer, the position of its last base, the first
// and last k-mers and a short-read flag; other characters produce nothing. A character passes
// an input register and the per-base update, and an end word's result is then registered in
// the result register, from which it is offered; the update of shift, mask and one 62-bit
// compare sets the rate of one word per cycle. The result register holds one word, and input
// keeps flowing until a second read end meets a full result register. Register kmer_len
// (address 0, reset 15, 0 means 1) may only be written while idle; a write discards the read
// in progress, and the new length and mask are registered at the write itself.
module read_min_kmer_finder (
  input  logic                            clk,
  input  logic                            rst_n,
  rmk_in_if.sink                          in_ch,
  rmk_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rmk_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rmk_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rmk_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import rmk_pkg::*;

  cfg_t cfg;
  res_t res;
  logic res_valid;
  logic res_room;

  rmk_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rmk_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .res_room  (res_room),
    .res_valid (res_valid),
    .res       (res)
  );

  rmk_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_room  (res_room),
    .out_ch    (out_ch)
  );

endmodule

@@ tb/sv/tb_read_min_kmer_finder.sv @@
// testbench streaming reads into the minimum k-mer finder and checking each per-read summary word
module tb_read_min_kmer_finder;
  import rmk_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam logic [APB_ADDR_W-1:0] KMER_LEN_ADDR = {REG_KMER_LEN, 2'b00};

  class min_kmer_scoreboard;
    logic [KLEN_W-1:0] klen;
    logic [63:0]       rolling;
    logic [63:0]       best;
    logic [63:0]       prefix;
    logic [POS_W-1:0]  best_pos;
    int unsigned       bases_in;
    res_t              pending_minima[$];
    int unsigned       errors;

    function new();
      klen = KLEN_RESET;
      errors = 0;
      clear_read();
    endfunction

    function int unsigned k_bases();
      return (klen == '0) ? 1 : int'(klen);
    endfunction

    function logic [63:0] kmer_mask();
      return (64'd1 << (2 * k_bases())) - 64'd1;
    endfunction

    function void clear_read();
      rolling = '0;
      best = kmer_mask();
      best_pos = '0;
      bases_in = 0;
      prefix = '0;
    endfunction

    function void write_klen(logic [APB_DATA_W-1:0] v);
      klen = v[KLEN_W-1:0];
      clear_read();
    endfunction

    function void note_base(logic [CHAR_W-1:0] c, logic last);
      logic [CODE_W-1:0] code;
      int unsigned posn;
      int unsigned seen;
      res_t r;
      case (c)
        "A", "a": code = CODE_A;
        "C", "c": code = CODE_C;
        "G", "g": code = CODE_G;
        "T", "t": code = CODE_T;
        default:  code = CODE_OTHER;
      endcase
      posn = bases_in;
      // an unknown character ors its high bit into the previous base's slot
      rolling = ((rolling << 2) | 64'(code)) & kmer_mask();
      if (bases_in < POS_CAP) bases_in++;
      seen = posn + 1;
      if (seen == k_bases()) prefix = rolling;
      if (seen >= k_bases() && rolling < best) begin
        best = rolling;
        best_pos = posn[POS_W-1:0];
      end
      if (last) begin
        r.short_read   = (seen < k_bases());
        r.min_kmer     = best[KMER_W-1:0];
        r.min_position = r.short_read ? '0 : best_pos;
        r.first_kmer   = r.short_read ? rolling[KMER_W-1:0] : prefix[KMER_W-1:0];
        r.last_kmer    = rolling[KMER_W-1:0];
        pending_minima.push_back(r);
        clear_read();
      end
    endfunction

    function void field_check(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_summary(res_t got);
      res_t want;
      if (pending_minima.size() == 0) begin
        $display("%0t: summary word with none expected, got %h", $time, got);
        errors++;
        return;
      end
      want = pending_minima.pop_front();
      field_check("min_kmer", 64'(want.min_kmer), 64'(got.min_kmer));
      field_check("min_position", 64'(want.min_position), 64'(got.min_position));
      field_check("first_kmer", 64'(want.first_kmer), 64'(got.first_kmer));
      field_check("last_kmer", 64'(want.last_kmer), 64'(got.last_kmer));
      field_check("short_read", 64'(want.short_read), 64'(got.short_read));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rmk_in_if  in_ch ();
  rmk_out_if out_ch ();

  read_min_kmer_finder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  min_kmer_scoreboard sb;
  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_read_min_kmer_finder: FAIL");
      $finish;
    end
  end

  // result side: long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  always @(negedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_summary('{out_ch.min_kmer, out_ch.min_position, out_ch.first_kmer,
                         out_ch.last_kmer, out_ch.short_read});
  end

  function automatic logic [CHAR_W-1:0] pick_char();
    string bases;
    bases = "ACGTacgt";
    if ($urandom_range(0, 99) < 85) return bases[$urandom_range(0, 7)];
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  task automatic send_base(input logic [CHAR_W-1:0] c, input logic last);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.base_char <= c;
    in_ch.read_end <= last;
    do @(negedge clk); while (in_ch.ready !== 1'b1);
    @(posedge clk);
    sb.note_base(c, last);
  endtask

  task automatic send_text(input string s, input logic end_read);
    for (int i = 0; i < s.len(); i++) send_base(s[i], end_read && (i == s.len() - 1));
  endtask

  task automatic send_read(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_base(pick_char(), i == len - 1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_minima.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_kmer_len(input logic [APB_DATA_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= KMER_LEN_ADDR;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (pready !== 1'b1);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_klen(v);
    // wait until the registered clear has reset the read state under the new length
    repeat (2) @(posedge clk);
  endtask

  task automatic random_reads(input int unsigned budget);
    int unsigned sent;
    int unsigned k;
    int unsigned len;
    int unsigned roll;
    sent = 0;
    while (sent < budget) begin
      k = sb.k_bases();
      roll = $urandom_range(0, 99);
      if (roll < 12) len = $urandom_range(1, k);
      else if (roll < 20) len = k;
      else len = k + $urandom_range(1, k + 4);
      send_read(len);
      sent += len;
    end
  endtask

  initial begin
    int unsigned k_plan[8];
    int unsigned k;
    k_plan = '{31, 1, 0, 4, 2, 17, 9, 6};
    sb = new();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.base_char <= '0;
    in_ch.read_end <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset length, case mix, unknown characters, discard mid-read
    send_text("ACG", 1'b1);
    drain();
    write_kmer_len(32'd3);
    send_text("ACGT", 1'b1);
    send_text("tgca", 1'b1);
    send_text("GNA", 1'b1);
    send_base(8'h00, 1'b0);
    send_base(8'hFF, 1'b1);
    send_text("TT", 1'b0);
    drain();
    write_kmer_len(32'd0);
    send_text("G", 1'b1);
    send_text("CA", 1'b1);
    drain();

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 59; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 59; end
        default: begin in_idle_pct = 26; out_stall_pct = 26; end
      endcase
      for (int j = 0; j < 2; j++) begin
        k = k_plan[2 * mode + j];
        drain();
        if (mode == 3) write_kmer_len({27'($urandom()), 5'(k)});
        else write_kmer_len(32'(k));
        random_reads(140);
        if (mode == 0 && j == 1) begin
          // receiver holds off while reads of one or two bases pile up behind the result register
          in_ch.valid <= 1'b0;
          @(negedge clk);
          hold_req++;
          @(posedge clk);
          repeat (60) send_read($urandom_range(1, 2));
          drain();
          random_reads(40);
        end
      end
    end

    drain();
    if (sb.errors == 0) $display("tb_read_min_kmer_finder: PASS");
    else $display("tb_read_min_kmer_finder: FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/rmk_pkg.sv
hw/rtl/rmk_if.sv
hw/rtl/rmk_cfg.sv
hw/rtl/rmk_core.sv
hw/rtl/rmk_out.sv
hw/rtl/read_min_kmer_finder.sv
tb/sv/tb_read_min_kmer_finder.sv
